/* rtl/core/ctst_pkg.sv */
package ctst_pkg;

    // Default number of entries in the value cycle.
    localparam int MAX_VALUES_DEF = 16;

    // Fixed payload widths.
    localparam int KIND_W = 2;
    localparam int ACC_W  = 8;
    localparam int DATA_W = 8;

    // Item kinds. The fourth code has no meaning and is dropped.
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_THR  = 2'd1,
        KIND_VAL  = 2'd2
    } kind_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_THR,
        ST_CMP,
        ST_VAL,
        ST_FIN_RD,
        ST_FIN,
        ST_FLUSH
    } state_t;

endpackage

/* rtl/core/ctst_if.sv */
interface ctst_in_if #(
    parameter int MAX_VALUES = ctst_pkg::MAX_VALUES_DEF
);
    localparam int IDX_W = $clog2(MAX_VALUES + 1);

    logic                        valid;
    logic                        ready;
    logic [ctst_pkg::KIND_W-1:0] kind;
    logic [ctst_pkg::ACC_W-1:0]  elapsed_frames;
    logic [IDX_W-1:0]            entry_index;
    logic [ctst_pkg::DATA_W-1:0] entry_data;

    modport source (
        output valid, kind, elapsed_frames, entry_index, entry_data,
        input  ready
    );
    modport sink (
        input  valid, kind, elapsed_frames, entry_index, entry_data,
        output ready
    );
endinterface

interface ctst_out_if;
    logic                        valid;
    logic                        ready;
    logic [ctst_pkg::DATA_W-1:0] tick_value;
    logic                        last_of_run;

    modport source (
        output valid, tick_value, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, tick_value, last_of_run,
        output ready
    );
endinterface

/* rtl/core/ctst_ram.sv */
module ctst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/cyclic_threshold_sequence_timer_unit.sv */
// Cyclic threshold sequence timer.
//
// Input channel in_ch carries one item per beat. A tick item (kind tick)
// adds elapsed_frames to an 8-bit frame accumulator that saturates at 255;
// the block then walks the threshold table from the current target index and
// sends one output beat on out_ch for every threshold reached, carrying the
// value stored for that index. At the final index (the cycle length in the
// count register, clamped to 1..MAX_VALUES) the final threshold is taken off
// the accumulator, the index returns to 1, value entry 0 is sent and the tick
// ends; its last beat has last_of_run set. The count register is written over
// cfg_we/cfg_wdata. A load item writes one table entry at acceptance.
//
// Flow control: in_ch is ready only while the sequencer is idle. A load item
// leaves the sequencer idle; a tick keeps in_ch not ready through one table
// read and one compare per step, a push per value reached, a further read and
// push on the wrap to index 1 and a final flush of the holding register.
// Beats pass a holding register and an output register; when out_ch stalls,
// the sequencer waits at the next push. Reset clears the accumulator, sets the
// target index and the count to 1 and drops any beat in flight; tables keep.
module cyclic_threshold_sequence_timer_unit #(
    parameter int MAX_VALUES = ctst_pkg::MAX_VALUES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ctst_in_if.sink           in_ch,
    ctst_out_if.source        out_ch,
    input  logic              cfg_we,
    input  logic [$clog2(MAX_VALUES + 1)-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_VALUES + 1);
    localparam int VA_W  = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int ACC_W = ctst_pkg::ACC_W;
    localparam int DAT_W = ctst_pkg::DATA_W;

    ctst_pkg::state_t state_reg, state_next;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [IDX_W-1:0] target_reg, target_next;
    logic [IDX_W-1:0] count_reg;
    logic             pend_valid_reg, pend_valid_next;
    logic [DAT_W-1:0] pend_value_reg, pend_value_next;
    logic             out_valid_reg, out_valid_next;
    logic [DAT_W-1:0] out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;

    logic [IDX_W-1:0] fin_idx;
    logic             accept;
    logic             out_free;
    logic             can_push;
    logic [ACC_W:0]   sum;
    logic [ACC_W:0]   diff;
    logic             ge;

    logic             thr_we;
    logic             val_we;
    logic [IDX_W-1:0] thr_raddr;
    logic [VA_W-1:0]  val_raddr;
    logic [DAT_W-1:0] thr_rdata;
    logic [DAT_W-1:0] val_rdata;

    // Final index is the count register clamped to the table range.
    always_comb
    begin
        if (count_reg == '0)
        begin
            fin_idx = IDX_W'(1);
        end
        else if (count_reg > IDX_W'(MAX_VALUES))
        begin
            fin_idx = IDX_W'(MAX_VALUES);
        end
        else
        begin
            fin_idx = count_reg;
        end
    end

    assign in_ch.ready = (state_reg == ctst_pkg::ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // A new beat can enter the output register when it is empty or draining.
    assign out_free = !out_valid_reg || out_ch.ready;
    assign can_push = !pend_valid_reg || out_free;

    assign sum = {1'b0, acc_reg} + {1'b0, in_ch.elapsed_frames};

    // Shared compare/subtract unit: accumulator against the threshold just read.
    assign diff = {1'b0, acc_reg} - {1'b0, thr_rdata};
    assign ge   = !diff[ACC_W];

    // Table writes happen only while idle, so they never meet a walk.
    assign thr_we = accept && (in_ch.kind == ctst_pkg::KIND_THR)
                    && (in_ch.entry_index <= IDX_W'(MAX_VALUES));
    assign val_we = accept && (in_ch.kind == ctst_pkg::KIND_VAL)
                    && (in_ch.entry_index < IDX_W'(MAX_VALUES));

    // The wrap step reads the final threshold and value entry 0; addresses
    // are held through the waiting state so the read data stays put.
    always_comb
    begin
        if ((state_reg == ctst_pkg::ST_FIN_RD) || (state_reg == ctst_pkg::ST_FIN))
        begin
            thr_raddr = fin_idx;
            val_raddr = '0;
        end
        else
        begin
            thr_raddr = target_reg;
            val_raddr = target_reg[VA_W-1:0];
        end
    end

    ctst_ram #(
        .WIDTH (DAT_W),
        .DEPTH (MAX_VALUES + 1)
    ) u_thr_ram (
        .clk   (clk),
        .we    (thr_we),
        .waddr (in_ch.entry_index),
        .wdata (in_ch.entry_data),
        .raddr (thr_raddr),
        .rdata (thr_rdata)
    );

    ctst_ram #(
        .WIDTH (DAT_W),
        .DEPTH (MAX_VALUES)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (in_ch.entry_index[VA_W-1:0]),
        .wdata (in_ch.entry_data),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctst_pkg::ST_IDLE:
            begin
                if (accept && (in_ch.kind == ctst_pkg::KIND_TICK))
                begin
                    state_next = ctst_pkg::ST_RD_THR;
                end
            end
            ctst_pkg::ST_RD_THR:
            begin
                state_next = ctst_pkg::ST_CMP;
            end
            ctst_pkg::ST_CMP:
            begin
                if (!ge)
                begin
                    state_next = ctst_pkg::ST_FLUSH;
                end
                else if (target_reg >= fin_idx)
                begin
                    state_next = ctst_pkg::ST_FIN_RD;
                end
                else
                begin
                    state_next = ctst_pkg::ST_VAL;
                end
            end
            ctst_pkg::ST_VAL:
            begin
                if (can_push)
                begin
                    state_next = ctst_pkg::ST_RD_THR;
                end
            end
            ctst_pkg::ST_FIN_RD:
            begin
                state_next = ctst_pkg::ST_FIN;
            end
            ctst_pkg::ST_FIN:
            begin
                if (can_push)
                begin
                    state_next = ctst_pkg::ST_FLUSH;
                end
            end
            ctst_pkg::ST_FLUSH:
            begin
                if (can_push)
                begin
                    state_next = ctst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctst_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic. A reached value is parked in the holding
    // register until the walk knows whether another one follows; only then
    // is its last_of_run flag known.
    always_comb
    begin
        acc_next        = acc_reg;
        target_next     = target_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ctst_pkg::ST_IDLE:
            begin
                if (accept && (in_ch.kind == ctst_pkg::KIND_TICK))
                begin
                    acc_next = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
                end
            end
            ctst_pkg::ST_VAL:
            begin
                if (can_push)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = pend_value_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_value_next = val_rdata;
                    target_next     = target_reg + IDX_W'(1);
                end
            end
            ctst_pkg::ST_FIN:
            begin
                if (can_push)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = pend_value_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_value_next = val_rdata;
                    acc_next        = ge ? diff[ACC_W-1:0] : '0;
                    target_next     = IDX_W'(1);
                end
            end
            ctst_pkg::ST_FLUSH:
            begin
                if (can_push && pend_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pend_value_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ctst_pkg::ST_IDLE;
            acc_reg        <= '0;
            target_reg     <= IDX_W'(1);
            count_reg      <= IDX_W'(1);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            target_reg     <= target_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg <= pend_value_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.tick_value  = out_value_reg;
    assign out_ch.last_of_run = out_last_reg;

endmodule

/* verif/tb.sv */
// Self-checking bench for the cyclic threshold sequence timer. Every accepted
// input beat is fed to a predictor that mirrors the accumulator, target index,
// tables and count register; the beats it expects are queued and compared in
// order against the beats leaving out_ch.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXV = ctst_pkg::MAX_VALUES_DEF;

    // Kind code that the block ignores. It has no member in kind_t.
    localparam logic [ctst_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

    // A tick that reaches no threshold sends no beat but still holds the
    // block through a read, a compare and the flush; this leaves ample room after the last beat.
    localparam int SETTLE_CYCLES = 48;

    // Roughly how many input beats the run sends before the last phase;
    // the last phase runs over by a few dozen.
    localparam int ITEM_TARGET = 190;

    typedef struct packed {
        logic [ctst_pkg::KIND_W-1:0] kind;
        logic [ctst_pkg::ACC_W-1:0]  elapsed_frames;
        logic [4:0]                  entry_index;
        logic [ctst_pkg::DATA_W-1:0] entry_data;
    } item_t;

    typedef struct packed {
        logic [ctst_pkg::DATA_W-1:0] tick_value;
        logic                        last_of_run;
    } beat_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;

    ctst_in_if #(.MAX_VALUES(MAXV)) in_ch();
    ctst_out_if                     out_ch();

    cyclic_threshold_sequence_timer_unit #(
        .MAX_VALUES(MAXV)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state. It follows the block's architectural state exactly,
    // updated at the edge where the corresponding beat or write is accepted.
    logic [ctst_pkg::ACC_W-1:0]  acc_model;
    int unsigned                 index_model;
    logic [4:0]                  count_model;
    logic [ctst_pkg::DATA_W-1:0] thr_model [0:MAXV];
    logic [ctst_pkg::DATA_W-1:0] val_model [0:MAXV-1];

    beat_t expected_beats[$];
    int    error_count;
    int    counted_items;
    bit    calm;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous upper bound; a correct run finishes in a small fraction of it.
    initial
    begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    // The count register is used clamped to 1..MAXV.
    function automatic int unsigned final_slot(input logic [4:0] cnt);
        if (cnt == 5'd0)
        begin
            return 1;
        end
        if (cnt > MAXV)
        begin
            return MAXV;
        end
        return cnt;
    endfunction

    // Adds the elapsed frames, saturating, then walks the thresholds from the
    // current target index. Each threshold reached queues one beat; reaching
    // the final slot takes the final threshold off the accumulator (floored
    // at zero), wraps the index to 1, queues value entry 0 and ends the tick.
    // The last queued beat of the tick carries the marker.
    function automatic void advance_timer(input logic [ctst_pkg::ACC_W-1:0] frames);
        int unsigned fin;
        int unsigned sum;
        int          emitted;
        beat_t       b;
        fin = final_slot(count_model);
        sum = acc_model + frames;
        acc_model = (sum > 255) ? 8'hFF : 8'(sum);
        emitted = 0;
        while (index_model <= MAXV && acc_model >= thr_model[index_model])
        begin
            b.last_of_run = 1'b0;
            if (index_model >= fin)
            begin
                acc_model = (acc_model >= thr_model[fin]) ?
                            acc_model - thr_model[fin] : 8'h00;
                index_model = 1;
                b.tick_value = val_model[0];
                expected_beats.push_back(b);
                emitted++;
                break;
            end
            b.tick_value = val_model[index_model];
            expected_beats.push_back(b);
            emitted++;
            index_model++;
        end
        if (emitted > 0)
        begin
            expected_beats[$].last_of_run = 1'b1;
        end
    endfunction

    // Drives one input beat, optionally after a random gap, and waits for the
    // handshake. The predictor is updated at the accepting edge. valid stays
    // high afterwards so that the next call can follow back to back; anything
    // that pauses the stream must lower it.
    task automatic push_beat(input item_t it);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= it.kind;
        in_ch.elapsed_frames <= it.elapsed_frames;
        in_ch.entry_index    <= it.entry_index;
        in_ch.entry_data     <= it.entry_data;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        counted_items++;
        case (it.kind)
            ctst_pkg::KIND_TICK:
            begin
                advance_timer(it.elapsed_frames);
            end
            ctst_pkg::KIND_THR:
            begin
                if (it.entry_index <= MAXV)
                begin
                    thr_model[it.entry_index] = it.entry_data;
                end
            end
            ctst_pkg::KIND_VAL:
            begin
                if (it.entry_index < MAXV)
                begin
                    val_model[it.entry_index] = it.entry_data;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic tick(input int frames);
        push_beat('{ctst_pkg::KIND_TICK, 8'(frames), 5'd0, 8'd0});
    endtask

    task automatic load_thr(input int idx, input int data);
        push_beat('{ctst_pkg::KIND_THR, 8'd0, 5'(idx), 8'(data)});
    endtask

    task automatic load_val(input int idx, input int data);
        push_beat('{ctst_pkg::KIND_VAL, 8'd0, 5'(idx), 8'(data)});
    endtask

    // Stops the input stream and waits until every predicted beat has been
    // seen, then lets the sequencer finish any walk that produced nothing.
    // Whatever is still expected after the guard is reported and dropped.
    task automatic settle();
        int guard;
        in_ch.valid <= 1'b0;
        guard = 0;
        while (expected_beats.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_beats.size() != 0)
        begin
            $error("%0d expected beats never arrived", expected_beats.size());
            error_count++;
            expected_beats.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while the block is idle, i.e. right after settle().
    task automatic write_count(input logic [4:0] cnt);
        cfg_we    <= 1'b1;
        cfg_wdata <= cnt;
        @(posedge clk);
        count_model = cnt;
        cfg_we <= 1'b0;
    endtask

    // Every table entry gets a value before the first tick, so no read of
    // an entry that was never written can happen. Thresholds start at zero.
    task automatic init_tables();
        for (int i = 0; i <= MAXV; i++)
        begin
            load_thr(i, 0);
        end
        for (int i = 0; i < MAXV; i++)
        begin
            load_val(i, $urandom_range(0, 255));
        end
    endtask

    // Count at its reset value of one: every reached threshold wraps at once.
    // Covers a tick with nothing reached, the ignored kind, out-of-range
    // entry writes, saturation of the accumulator and both data extremes.
    task automatic test_single_value_cycle();
        tick(0);
        push_beat('{KIND_NONE, 8'hFF, 5'h1F, 8'hFF});
        load_thr(1, 5);
        tick(0);
        tick(5);
        tick(255);
        tick(255);
        load_thr(17, 8'hA5);
        load_thr(31, 8'h5A);
        load_val(16, 8'hC3);
        load_val(31, 8'h3C);
        load_thr(MAXV, 0);
        load_val(MAXV - 1, 255);
        load_val(0, 0);
        // A threshold of 255 with a saturated sum clears the accumulator.
        load_thr(1, 255);
        tick(255);
    endtask

    // All thresholds zero with the largest count: one tick yields the
    // longest possible run of beats, ending on value entry 0.
    task automatic test_full_cycle();
        settle();
        write_count(5'd16);
        load_thr(1, 0);
        tick(0);
    endtask

    // Stop part way through the cycle, lower the count below the target
    // index, and let the next tick wrap from beyond the final slot with a
    // final threshold larger than the accumulator.
    task automatic test_index_past_final();
        settle();
        write_count(5'd4);
        load_thr(1, 10);
        load_thr(2, 20);
        load_thr(3, 30);
        load_thr(4, 40);
        tick(25);
        settle();
        write_count(5'd2);
        load_thr(2, 200);
        tick(10);
    endtask

    // One random beat within a phase. Mostly ticks sized against the current
    // final threshold so the cycle keeps turning, some in-range table edits,
    // and some beats that the block must drop.
    task automatic random_item(input int unsigned fin);
        int r;
        int span;
        r = $urandom_range(0, 19);
        span = thr_model[fin] / 2 + 4;
        if (r < 14)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                tick($urandom_range(0, 255));
            end
            else
            begin
                tick($urandom_range(0, span));
            end
        end
        else if (r < 16)
        begin
            load_thr($urandom_range(0, MAXV), $urandom_range(0, 255));
        end
        else if (r < 17)
        begin
            load_val($urandom_range(0, MAXV - 1), $urandom_range(0, 255));
        end
        else if (r < 18)
        begin
            push_beat('{KIND_NONE, 8'($urandom_range(0, 255)),
                        5'($urandom_range(0, 31)), 8'($urandom_range(0, 255))});
        end
        else if (r < 19)
        begin
            load_thr($urandom_range(MAXV + 1, 31), $urandom_range(0, 255));
        end
        else
        begin
            load_val($urandom_range(MAXV, 31), $urandom_range(0, 255));
        end
    endtask

    // Phases of random traffic. Each phase picks a count (the extremes
    // first), usually reloads an ascending threshold table with random
    // steps and fresh values, then sends a stretch of random beats. The
    // final stretch runs with no idling on either side.
    task automatic test_random_cycles();
        int          phase;
        int          level;
        int          step_max;
        int unsigned fin;
        logic [4:0]  cnt;
        phase = 0;
        while (counted_items < ITEM_TARGET)
        begin
            if (counted_items >= ITEM_TARGET - 40)
            begin
                calm = 1'b1;
            end
            settle();
            case (phase)
                0:       cnt = 5'd31;
                1:       cnt = 5'd0;
                2:       cnt = 5'd16;
                default: cnt = 5'($urandom_range(0, 31));
            endcase
            write_count(cnt);
            fin = final_slot(cnt);
            if (phase < 3 || $urandom_range(0, 1) == 0)
            begin
                level = 0;
                step_max = 255 / fin;
                for (int i = 1; i <= fin; i++)
                begin
                    level += $urandom_range(0, step_max);
                    load_thr(i, level);
                end
                for (int i = 0; i < fin; i++)
                begin
                    load_val(i, $urandom_range(0, 255));
                end
            end
            repeat ($urandom_range(15, 35))
            begin
                random_item(fin);
            end
            phase++;
        end
    endtask

    // Output side: random stall bursts, except in the calm stretch.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Every accepted output beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: tick_value %0h last_of_run %0b",
                       out_ch.tick_value, out_ch.last_of_run);
                error_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (out_ch.tick_value !== want.tick_value)
                begin
                    $error("tick_value: expected %0h, actual %0h",
                           want.tick_value, out_ch.tick_value);
                    error_count++;
                end
                if (out_ch.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, actual %0b",
                           want.last_of_run, out_ch.last_of_run);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= 5'd0;
        in_ch.valid          <= 1'b0;
        in_ch.kind           <= ctst_pkg::KIND_TICK;
        in_ch.elapsed_frames <= 8'd0;
        in_ch.entry_index    <= 5'd0;
        in_ch.entry_data     <= 8'd0;
        acc_model     = 8'd0;
        index_model   = 1;
        count_model   = 5'd1;
        error_count   = 0;
        counted_items = 0;
        calm          = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        init_tables();
        test_single_value_cycle();
        test_full_cycle();
        test_index_past_final();
        test_random_cycles();
        settle();

        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
